FILE: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and payload types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   // Pool geometry
   localparam int MAX_BLOCKS      = 64;
   localparam int ADDR_WIDTH      = 48;
   localparam int SIZE_WIDTH      = 17;
   localparam int CFG_COUNT_WIDTH = 7;
   localparam int COUNT_WIDTH     = 7;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_IDX_W       = 2;

   // Internal widths
   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int ROW_SH   = 3;
   localparam int ROW_BITS = 1 << ROW_SH;
   localparam int ROWS     = (MAX_BLOCKS + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SPAN_W   = CNT_W + SIZE_WIDTH;
   localparam int STEP_W   = $clog2(SPAN_W);

   // Reset values of the configuration
   localparam int RESET_SIZE  = 4096;
   localparam int RESET_COUNT = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   // Operation codes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK,
      STATUS_NO_FREE,
      STATUS_OUTSIDE,
      STATUS_NOT_IN_USE
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SPAN,
      S_CHECK,
      S_DIV,
      S_REL_RD,
      S_REL_WR,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_ADDR_MUL,
      S_ADDR_ADD,
      S_DONE
   } state_type;

   typedef struct packed {
      logic                  op;
      logic [ADDR_WIDTH-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]   block_address;
      logic [STATUS_WIDTH-1:0] status;
      logic                    owned;
      logic [COUNT_WIDTH-1:0]  blocks_in_use;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

FILE: hw/rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle. Turns a pool offset into a
// block index.
// ----------------------------------------------------------------------------
module fbpa_div
   import fbpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [SPAN_W-1:0]     dividend,
   input  logic [SIZE_WIDTH-1:0] divisor,
   output logic [SPAN_W-1:0]     quotient,
   output div_stat_type          stat
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [SIZE_WIDTH-1:0] rem_ff;
   logic [SPAN_W-1:0]     quo_ff;
   logic [SIZE_WIDTH-1:0] dsr_ff;

   logic [SIZE_WIDTH:0]   trial_w;
   logic                  fits_w;
   logic [SIZE_WIDTH:0]   diff_w;

   // One trial subtract per step
   always_comb begin
      trial_w = {rem_ff, quo_ff[SPAN_W-1]};
      fits_w  = trial_w >= {1'b0, dsr_ff};
      diff_w  = trial_w - {1'b0, dsr_ff};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            if (step_ff == STEP_W'(SPAN_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   // Datapath: dividend shifts out at the top, quotient bits shift in below
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits_w ? diff_w[SIZE_WIDTH-1:0] : trial_w[SIZE_WIDTH-1:0];
         quo_ff <= {quo_ff[SPAN_W-2:0], fits_w};
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

FILE: hw/rtl/fixed_block_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Bitmap allocator for a pool of equal-size blocks. In-use bits sit in a RAM
// of 8-bit rows; allocate scans rows for the lowest free block, release
// divides the offset by the block size and clears one bit.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    req_data  (op, address)
//   rsp      out  rsp_valid/rsp_ready    rsp_data  (block_address, status,
//                                                   owned, blocks_in_use)
//   csr      in   csr_we                 csr_index, csr_wdata
//
// One request at a time. Release runs the bit-serial divider, then reads and
// rewrites one bitmap row. Allocate reads and checks rows of 8 blocks in turn
// in a RAM read-check loop until it finds a free block or passes the pool.
// The next request is taken while a response waits in the output register;
// a stalled response holds the following one in its final state.
// Synchronous reset clears every in-use bit at once through per-row valid
// flags; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit
   import fbpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [ADDR_WIDTH-1:0] csr_wdata
);

   state_type state_ff, state_in;

   // Configuration (block size and count kept in effective form)
   logic [ADDR_WIDTH-1:0] base_ff;
   logic [SIZE_WIDTH-1:0] size_ff;
   logic [CNT_W-1:0]      ecount_ff;

   // Pool state outside the RAM
   logic [CNT_W-1:0]      count_ff;
   logic [ROWS-1:0]       row_valid_ff;

   // Response register
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // Request working registers
   logic                  op_ff;
   logic [ADDR_WIDTH-1:0] addr_ff;
   logic [ADDR_WIDTH-1:0] offset_ff;
   logic                  below_ff;
   logic [SPAN_W-1:0]     prod_ff;
   logic                  owned_ff;
   status_type            status_ff;
   logic [ADDR_WIDTH-1:0] res_addr_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [ROW_SH-1:0]     bit_ff;
   logic [IDX_W-1:0]      idx_ff;

   // Combinational
   logic [CFG_COUNT_WIDTH-1:0] cfg_count_w;
   logic [SIZE_WIDTH-1:0]      cfg_size_w;
   logic [ADDR_WIDTH:0]        diff_w;
   logic [CNT_W-1:0]           mul_a_w;
   logic [SPAN_W-1:0]          prod_w;
   logic                       owned_w;
   logic                       rsp_free_w;
   logic [ROW_BITS-1:0]        ram_rdata;
   logic [ROW_BITS-1:0]        row_data_w;
   logic [ROW_BITS-1:0]        ram_wdata;
   logic                       ram_we;
   logic                       found_w;
   logic [ROW_SH-1:0]          found_bit_w;
   logic [31:0]                scan_idx_w;
   logic                       last_row_w;
   logic                       bit_set_w;
   logic                       div_start;
   div_stat_type               div_stat;
   logic [SPAN_W-1:0]          div_quotient;
   logic [IDX_W-1:0]           div_idx_w;

   // In-use bitmap, one row of 8 blocks per entry
   fbpa_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock (clock),
      .we    (ram_we),
      .waddr (row_ff),
      .wdata (ram_wdata),
      .raddr (row_ff),
      .rdata (ram_rdata)
   );

   // Offset to block index
   fbpa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (SPAN_W'(offset_ff)),
      .divisor  (size_ff),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // Config write decode helpers
   always_comb begin
      cfg_count_w = csr_wdata[CFG_COUNT_WIDTH-1:0];
      cfg_size_w  = (csr_wdata[SIZE_WIDTH-1:0] == '0) ? SIZE_WIDTH'(1)
                                                      : csr_wdata[SIZE_WIDTH-1:0];
   end

   // Shared multiplier: pool span, then block offset for allocate
   always_comb begin
      mul_a_w = (state_ff == S_SPAN) ? ecount_ff : CNT_W'(idx_ff);
      prod_w  = SPAN_W'(mul_a_w) * SPAN_W'(size_ff);
   end

   // Range check
   always_comb begin
      diff_w     = {1'b0, addr_ff} - {1'b0, base_ff};
      owned_w    = !below_ff && (64'(offset_ff) < 64'(prod_ff));
      rsp_free_w = !rsp_valid_ff || rsp_ready;
      div_idx_w  = IDX_W'(div_quotient);
   end

   // Row inspection: lowest free block inside the pool, and the release bit
   always_comb begin
      row_data_w  = row_valid_ff[row_ff] ? ram_rdata : '0;
      found_w     = 1'b0;
      found_bit_w = '0;
      for (int b = ROW_BITS - 1; b >= 0; b--) begin
         if (!row_data_w[b] &&
             (((32'(row_ff) << ROW_SH) + 32'(b)) < 32'(ecount_ff))) begin
            found_w     = 1'b1;
            found_bit_w = ROW_SH'(b);
         end
      end
      scan_idx_w = (32'(row_ff) << ROW_SH) | 32'(found_bit_w);
      last_row_w = ((32'(row_ff) + 32'd1) << ROW_SH) >= 32'(ecount_ff);
      bit_set_w  = row_data_w[bit_ff];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SPAN;
         end
         S_SPAN: state_in = S_CHECK;
         S_CHECK: begin
            if (op_ff == OP_ALLOC) begin
               state_in = (ecount_ff == '0) ? S_DONE : S_SCAN_RD;
            end else begin
               state_in = owned_w ? S_DIV : S_DONE;
            end
         end
         S_DIV: begin
            if (div_stat.done) state_in = S_REL_RD;
         end
         S_REL_RD:   state_in = S_REL_WR;
         S_REL_WR:   state_in = S_DONE;
         S_SCAN_RD:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (found_w) begin
               state_in = S_ADDR_MUL;
            end else if (last_row_w) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN_RD;
            end
         end
         S_ADDR_MUL: state_in = S_ADDR_ADD;
         S_ADDR_ADD: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free_w) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_wdata = row_data_w;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_CHECK: div_start = (op_ff == OP_RELEASE) && owned_w;
         S_SCAN_CHK: begin
            ram_we    = found_w;
            ram_wdata = row_data_w | (ROW_BITS'(1) << found_bit_w);
         end
         S_REL_WR: begin
            ram_we    = bit_set_w;
            ram_wdata = row_data_w & ~(ROW_BITS'(1) << bit_ff);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         size_ff      <= SIZE_WIDTH'(RESET_SIZE);
         ecount_ff    <= CNT_W'(RESET_COUNT);
         count_ff     <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Configuration writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_BASE:  base_ff <= csr_wdata;
               CSR_SIZE:  size_ff <= cfg_size_w;
               CSR_COUNT: begin
                  if (32'(cfg_count_w) > 32'(MAX_BLOCKS)) begin
                     ecount_ff <= CNT_W'(MAX_BLOCKS);
                  end else begin
                     ecount_ff <= CNT_W'(cfg_count_w);
                  end
               end
               default: begin
                  base_ff <= base_ff;
               end
            endcase
         end

         // In-use count
         if (state_ff == S_SCAN_CHK && found_w) begin
            count_ff <= count_ff + 1'b1;
         end else if (state_ff == S_REL_WR && bit_set_w && count_ff != '0) begin
            count_ff <= count_ff - 1'b1;
         end

         // A written row becomes valid
         if (ram_we) begin
            row_valid_ff[row_ff] <= 1'b1;
         end

         // Response register
         if (state_ff == S_DONE && rsp_free_w) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_ff   <= req_data.op;
               addr_ff <= req_data.address;
            end
         end
         S_SPAN: begin
            prod_ff     <= prod_w;
            offset_ff   <= diff_w[ADDR_WIDTH-1:0];
            below_ff    <= diff_w[ADDR_WIDTH];
            res_addr_ff <= '0;
            status_ff   <= STATUS_OK;
         end
         S_CHECK: begin
            owned_ff <= owned_w;
            row_ff   <= '0;
            if (op_ff == OP_ALLOC && ecount_ff == '0) begin
               status_ff <= STATUS_NO_FREE;
            end else if (op_ff == OP_RELEASE && !owned_w) begin
               status_ff <= STATUS_OUTSIDE;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               idx_ff <= div_idx_w;
               row_ff <= ROW_W'(div_idx_w >> ROW_SH);
               bit_ff <= ROW_SH'(div_idx_w);
            end
         end
         S_REL_WR: begin
            if (!bit_set_w) status_ff <= STATUS_NOT_IN_USE;
         end
         S_SCAN_CHK: begin
            if (found_w) begin
               idx_ff <= IDX_W'(scan_idx_w);
            end else if (last_row_w) begin
               status_ff <= STATUS_NO_FREE;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end
         S_ADDR_MUL: prod_ff <= prod_w;
         S_ADDR_ADD: res_addr_ff <= base_ff + ADDR_WIDTH'(prod_ff);
         S_DONE: begin
            if (rsp_free_w) begin
               rsp_data_ff.block_address <= res_addr_ff;
               rsp_data_ff.status        <= status_ff;
               rsp_data_ff.owned         <= owned_ff;
               rsp_data_ff.blocks_in_use <= COUNT_WIDTH'(count_ff);
            end
         end
         default: begin
            op_ff <= op_ff;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // The count can never pass the number of bits that exist
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BLOCKS))
      else $error("in-use count above pool size");

   // A taken request always starts the span computation
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_SPAN)
      else $error("request taken outside idle");

   // Bitmap is only written by allocate or release commit
   a_ram_we_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN_CHK || state_ff == S_REL_WR))
      else $error("bitmap write in wrong state");

   // An out-of-pool status never comes with ownership
   a_outside_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_OUTSIDE |-> !rsp_data_ff.owned)
      else $error("outside status on owned address");

   // Divider is never restarted while running
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");
`endif

endmodule
